// ===== rtl/sbt_pkg.sv =====
// Shared constants and types for the source byte tokenizer.
package sbt_pkg;

   localparam int LINE_WIDTH = 16;
   localparam int COLUMN_WIDTH = 12;

   localparam logic [LINE_WIDTH-1:0] LINE_MAX = '1;
   localparam logic [COLUMN_WIDTH-1:0] COLUMN_MAX = '1;

   localparam int QUEUE_DEPTH = 4;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE = 8'h7D;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_STAR = 8'h2A;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [2:0] {
      KIND_WORD,
      KIND_DELIM,
      KIND_OP,
      KIND_QUOTE,
      KIND_BODY
   } kind_type;

   typedef struct packed {
      logic [7:0] lexeme_byte;
      logic lexeme_start;
      kind_type lexeme_kind;
      logic [LINE_WIDTH-1:0] line_number;
      logic [COLUMN_WIDTH-1:0] column_number;
      logic run_last;
      logic input_done;
   } lexeme_type;

endpackage

// ===== rtl/source_byte_tokenizer.sv =====
// Streaming tokenizer that tags kept source bytes and strips comments.
// Results of an accepted byte are written into the result queue and presented on the rsp_ channel from its head.
// Throughput: one byte per cycle while req_stall is low; a byte that yields two results takes two queue entries.
// Results wait in a four-entry queue; req_stall rises when fewer than two entries are free.
// Reset: synchronous, active high; clears the queue and the scanner state (line 1, column 0).
module source_byte_tokenizer (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_text_byte,
   input  logic req_end_of_input,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [7:0] rsp_lexeme_byte,
   output logic rsp_lexeme_start,
   output logic [2:0] rsp_lexeme_kind,
   output logic [sbt_pkg::LINE_WIDTH-1:0] rsp_line_number,
   output logic [sbt_pkg::COLUMN_WIDTH-1:0] rsp_column_number,
   output logic rsp_run_last,
   output logic rsp_input_done
);
   import sbt_pkg::*;

   typedef enum logic [2:0] {
      MODE_NORMAL,
      MODE_STRING,
      MODE_LINE_COMMENT,
      MODE_BLOCK,
      MODE_BLOCK_STAR
   } mode_type;

   mode_type mode_ff, mode_in;
   logic slash_pending_ff, slash_pending_in;
   logic [COLUMN_WIDTH-1:0] slash_column_ff, slash_column_in;
   logic word_open_ff, word_open_in;
   logic body_open_ff, body_open_in;
   logic [LINE_WIDTH-1:0] line_ff, line_in;
   logic [COLUMN_WIDTH-1:0] column_ff, column_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   lexeme_type queue_ff [QUEUE_DEPTH];
   lexeme_type queue_in [QUEUE_DEPTH];

   logic accept, pop;
   logic [7:0] ch;
   logic [COLUMN_WIDTH-1:0] col;
   logic is_newline, is_slash, is_star, is_quote, is_delim, is_op, is_space;
   logic normal_go, slash_pre, slash_eoi, byte_emit;
   lexeme_type byte_res, slash_res, res0, res1;
   logic [1:0] res_count;
   logic [COUNT_WIDTH-1:0] count_pop;

   assign accept = req_valid && !req_stall;
   assign pop = rsp_valid && !rsp_stall;
   assign req_stall = count_ff > COUNT_WIDTH'(QUEUE_DEPTH - 2);

   assign ch = req_text_byte;
   assign col = (column_ff != COLUMN_MAX) ? column_ff + 1'b1 : column_ff;
   assign is_newline = ch == CHAR_NEWLINE;
   assign is_slash = ch == CHAR_SLASH;
   assign is_star = ch == CHAR_STAR;
   assign is_quote = ch == CHAR_QUOTE;
   assign is_space = ch == CHAR_SPACE;
   assign is_delim = ch == CHAR_SEMICOLON || ch == CHAR_LPAREN || ch == CHAR_RPAREN ||
                     ch == CHAR_LBRACE || ch == CHAR_RBRACE || ch == CHAR_COMMA;
   assign is_op = is_star || ch == CHAR_PLUS || ch == CHAR_MINUS;

   // In normal mode the byte is scanned unless it completes a comment opener.
   assign normal_go = mode_ff == MODE_NORMAL && !(slash_pending_ff && (is_slash || is_star));
   assign slash_pre = mode_ff == MODE_NORMAL && slash_pending_ff && !is_slash && !is_star;
   assign slash_eoi = mode_ff == MODE_NORMAL && !slash_pending_ff && is_slash &&
                      req_end_of_input;

   always_comb begin
      byte_emit = 1'b0;
      byte_res.lexeme_byte = ch;
      byte_res.lexeme_start = 1'b1;
      byte_res.lexeme_kind = KIND_WORD;
      byte_res.line_number = line_ff;
      byte_res.column_number = col;
      byte_res.run_last = 1'b0;
      byte_res.input_done = req_end_of_input;
      if (mode_ff == MODE_STRING) begin
         byte_emit = 1'b1;
         if (is_quote) begin
            byte_res.lexeme_kind = KIND_QUOTE;
         end else begin
            byte_res.lexeme_kind = KIND_BODY;
            byte_res.lexeme_start = !body_open_ff;
         end
      end else if (normal_go) begin
         priority if (is_slash || is_space || is_newline) begin
            byte_emit = 1'b0;
         end else if (is_delim) begin
            byte_emit = 1'b1;
            byte_res.lexeme_kind = KIND_DELIM;
         end else if (is_op) begin
            byte_emit = 1'b1;
            byte_res.lexeme_kind = KIND_OP;
         end else if (is_quote) begin
            byte_emit = 1'b1;
            byte_res.lexeme_kind = KIND_QUOTE;
         end else begin
            byte_emit = 1'b1;
            byte_res.lexeme_start = !word_open_ff;
         end
      end

      slash_res.lexeme_byte = CHAR_SLASH;
      slash_res.lexeme_start = 1'b1;
      slash_res.lexeme_kind = KIND_OP;
      slash_res.line_number = line_ff;
      slash_res.column_number = slash_pre ? slash_column_ff : col;
      slash_res.run_last = 1'b0;
      slash_res.input_done = req_end_of_input;

      res_count = 2'(slash_pre) + 2'(byte_emit) + 2'(slash_eoi);
      res0 = slash_pre ? slash_res : (byte_emit ? byte_res : slash_res);
      res1 = byte_res;
      if (res_count == 2'd2) begin
         res1.run_last = 1'b1;
      end else begin
         res0.run_last = 1'b1;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      slash_pending_in = slash_pending_ff;
      slash_column_in = slash_column_ff;
      word_open_in = word_open_ff;
      body_open_in = body_open_ff;
      unique case (mode_ff)
         MODE_STRING: begin
            if (is_quote) begin
               mode_in = MODE_NORMAL;
               body_open_in = 1'b0;
            end else begin
               body_open_in = 1'b1;
            end
         end
         MODE_LINE_COMMENT: begin
            if (is_newline) begin
               mode_in = MODE_NORMAL;
            end
         end
         MODE_BLOCK: begin
            if (is_star) begin
               mode_in = MODE_BLOCK_STAR;
            end
         end
         MODE_BLOCK_STAR: begin
            if (is_slash) begin
               mode_in = MODE_NORMAL;
            end else if (!is_star) begin
               mode_in = MODE_BLOCK;
            end
         end
         default: begin
            slash_pending_in = !slash_pending_ff && is_slash;
            if (slash_pending_ff && is_slash) begin
               mode_in = MODE_LINE_COMMENT;
            end else if (slash_pending_ff && is_star) begin
               mode_in = MODE_BLOCK;
            end else begin
               word_open_in = !(is_slash || is_delim || is_op || is_quote || is_space ||
                                is_newline);
               if (is_slash) begin
                  slash_column_in = col;
               end
               if (is_quote) begin
                  mode_in = MODE_STRING;
                  body_open_in = 1'b0;
               end
            end
         end
      endcase

      if (is_newline) begin
         line_in = (line_ff != LINE_MAX) ? line_ff + 1'b1 : line_ff;
         column_in = '0;
      end else begin
         line_in = line_ff;
         column_in = col;
      end

      if (req_end_of_input) begin
         mode_in = MODE_NORMAL;
         slash_pending_in = 1'b0;
         slash_column_in = '0;
         word_open_in = 1'b0;
         body_open_in = 1'b0;
         line_in = LINE_WIDTH'(1);
         column_in = '0;
      end
   end

   always_comb begin
      count_pop = count_ff - COUNT_WIDTH'(pop);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && i < QUEUE_DEPTH - 1) begin
            queue_in[i] = queue_ff[i + 1];
         end else begin
            queue_in[i] = queue_ff[i];
         end
         if (accept && res_count != 2'd0 && count_pop == COUNT_WIDTH'(i)) begin
            queue_in[i] = res0;
         end
         if (accept && res_count == 2'd2 && count_pop + 1'b1 == COUNT_WIDTH'(i)) begin
            queue_in[i] = res1;
         end
      end
      count_in = count_pop + (accept ? COUNT_WIDTH'(res_count) : COUNT_WIDTH'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         slash_pending_ff <= 1'b0;
         slash_column_ff <= '0;
         word_open_ff <= 1'b0;
         body_open_ff <= 1'b0;
         line_ff <= LINE_WIDTH'(1);
         column_ff <= '0;
         count_ff <= '0;
      end else begin
         if (accept) begin
            mode_ff <= mode_in;
            slash_pending_ff <= slash_pending_in;
            slash_column_ff <= slash_column_in;
            word_open_ff <= word_open_in;
            body_open_ff <= body_open_in;
            line_ff <= line_in;
            column_ff <= column_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
   end

   assign rsp_valid = count_ff != '0;
   assign rsp_lexeme_byte = queue_ff[0].lexeme_byte;
   assign rsp_lexeme_start = queue_ff[0].lexeme_start;
   assign rsp_lexeme_kind = queue_ff[0].lexeme_kind;
   assign rsp_line_number = queue_ff[0].line_number;
   assign rsp_column_number = queue_ff[0].column_number;
   assign rsp_run_last = queue_ff[0].run_last;
   assign rsp_input_done = queue_ff[0].input_done;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_room_on_accept: assert property (@(posedge clock) disable iff (reset)
      accept |-> count_ff <= COUNT_WIDTH'(QUEUE_DEPTH - 2))
      else $error("transaction accepted without room for two results");

   a_slash_in_normal: assert property (@(posedge clock) disable iff (reset)
      slash_pending_ff |-> mode_ff == MODE_NORMAL)
      else $error("held slash outside normal mode");

   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_input |=> line_ff == LINE_WIDTH'(1) && !slash_pending_ff &&
      mode_ff == MODE_NORMAL)
      else $error("scanner state not cleared after final byte");

endmodule

// ===== tb/sv/source_byte_tokenizer_tb.sv =====
// Self-checking testbench for the source byte tokenizer with a lexeme scoreboard.
module source_byte_tokenizer_tb;
   import sbt_pkg::*;

   class lexeme_tracker;
      typedef enum logic [2:0] {
         SCAN_NORMAL,
         SCAN_STRING,
         SCAN_LINE_NOTE,
         SCAN_BLOCK,
         SCAN_BLOCK_STAR
      } scan_type;

      scan_type mode;
      bit slash_held;
      logic [COLUMN_WIDTH-1:0] slash_col;
      bit in_word;
      bit body_sent;
      logic [LINE_WIDTH-1:0] cur_line;
      logic [COLUMN_WIDTH-1:0] cur_col;
      lexeme_type run[$];
      lexeme_type expected_lexemes[$];
      int mismatch_count;

      function new();
         restart();
         mismatch_count = 0;
      endfunction

      function void restart();
         mode = SCAN_NORMAL;
         slash_held = 0;
         slash_col = '0;
         in_word = 0;
         body_sent = 0;
         cur_line = 1;
         cur_col = '0;
      endfunction

      function void add(logic [7:0] b, logic st, kind_type k, logic [LINE_WIDTH-1:0] ln,
                        logic [COLUMN_WIDTH-1:0] cl, logic done);
         lexeme_type r;
         r = '0;
         r.lexeme_byte = b;
         r.lexeme_start = st;
         r.lexeme_kind = k;
         r.line_number = ln;
         r.column_number = cl;
         r.run_last = 1'b0;
         r.input_done = done;
         run = {run, r};
      endfunction

      // Works out the lexemes that one accepted transaction produces.
      function void note_byte(logic [7:0] b, logic eoi);
         logic [LINE_WIDTH-1:0] ln;
         logic [COLUMN_WIDTH-1:0] cl;
         bit nl;
         bit consumed;
         run.delete();
         ln = cur_line;
         cl = (cur_col != COLUMN_MAX) ? cur_col + 1'b1 : COLUMN_MAX;
         nl = (b == CHAR_NEWLINE);
         consumed = 0;
         case (mode)
            SCAN_STRING: begin
               if (b == CHAR_QUOTE) begin
                  add(b, 1'b1, KIND_QUOTE, ln, cl, eoi);
                  mode = SCAN_NORMAL;
                  body_sent = 0;
               end else begin
                  add(b, !body_sent, KIND_BODY, ln, cl, eoi);
                  body_sent = 1;
               end
            end
            SCAN_LINE_NOTE: begin
               if (nl) mode = SCAN_NORMAL;
            end
            SCAN_BLOCK: begin
               if (b == CHAR_STAR) mode = SCAN_BLOCK_STAR;
            end
            SCAN_BLOCK_STAR: begin
               if (b == CHAR_SLASH) mode = SCAN_NORMAL;
               else if (b != CHAR_STAR) mode = SCAN_BLOCK;
            end
            default: begin
               if (slash_held) begin
                  slash_held = 0;
                  if (b == CHAR_SLASH) begin
                     mode = SCAN_LINE_NOTE;
                     consumed = 1;
                  end else if (b == CHAR_STAR) begin
                     mode = SCAN_BLOCK;
                     consumed = 1;
                  end else begin
                     add(CHAR_SLASH, 1'b1, KIND_OP, ln, slash_col, eoi);
                  end
               end
               if (!consumed) begin
                  if (b == CHAR_SLASH) begin
                     in_word = 0;
                     slash_held = 1;
                     slash_col = cl;
                  end else if (b inside {CHAR_SEMICOLON, CHAR_LPAREN, CHAR_RPAREN,
                                         CHAR_LBRACE, CHAR_RBRACE, CHAR_COMMA}) begin
                     in_word = 0;
                     add(b, 1'b1, KIND_DELIM, ln, cl, eoi);
                  end else if (b inside {CHAR_STAR, CHAR_PLUS, CHAR_MINUS}) begin
                     in_word = 0;
                     add(b, 1'b1, KIND_OP, ln, cl, eoi);
                  end else if (b == CHAR_QUOTE) begin
                     in_word = 0;
                     add(b, 1'b1, KIND_QUOTE, ln, cl, eoi);
                     mode = SCAN_STRING;
                     body_sent = 0;
                  end else if (b == CHAR_SPACE || nl) begin
                     in_word = 0;
                  end else begin
                     add(b, !in_word, KIND_WORD, ln, cl, eoi);
                     in_word = 1;
                  end
               end
            end
         endcase
         if (nl) begin
            if (cur_line != LINE_MAX) cur_line = cur_line + 1'b1;
            cur_col = '0;
         end else begin
            cur_col = cl;
         end
         if (eoi) begin
            if (slash_held) add(CHAR_SLASH, 1'b1, KIND_OP, ln, slash_col, eoi);
            restart();
         end
         if (run.size() > 0) run[run.size()-1].run_last = 1'b1;
         foreach (run[i]) expected_lexemes = {expected_lexemes, run[i]};
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      // Compares one accepted result transaction with the oldest expected lexeme.
      function void check_lexeme(lexeme_type got);
         lexeme_type want;
         if (expected_lexemes.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, actual byte %0h", $time,
                     got.lexeme_byte);
         end else begin
            want = expected_lexemes.pop_front();
            compare_field("lexeme_byte", want.lexeme_byte, got.lexeme_byte);
            compare_field("lexeme_start", want.lexeme_start, got.lexeme_start);
            compare_field("lexeme_kind", want.lexeme_kind, got.lexeme_kind);
            compare_field("line_number", want.line_number, got.line_number);
            compare_field("column_number", want.column_number, got.column_number);
            compare_field("run_last", want.run_last, got.run_last);
            compare_field("input_done", want.input_done, got.input_done);
         end
      endfunction
   endclass

   localparam int STALL_LIMIT = 1000;
   localparam int HOLD_CYCLES = 60;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [7:0] req_text_byte;
   logic req_end_of_input;
   logic rsp_valid;
   logic rsp_stall;
   logic [7:0] rsp_lexeme_byte;
   logic rsp_lexeme_start;
   logic [2:0] rsp_lexeme_kind;
   logic [LINE_WIDTH-1:0] rsp_line_number;
   logic [COLUMN_WIDTH-1:0] rsp_column_number;
   logic rsp_run_last;
   logic rsp_input_done;

   lexeme_tracker tracker;
   int sender_gap_pct;
   int receiver_stall_pct;
   int hold_request;
   int hold_left;
   int idle_cycles;
   int bytes_sent;

   source_byte_tokenizer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_text_byte(req_text_byte),
      .req_end_of_input(req_end_of_input),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_lexeme_byte(rsp_lexeme_byte),
      .rsp_lexeme_start(rsp_lexeme_start),
      .rsp_lexeme_kind(rsp_lexeme_kind),
      .rsp_line_number(rsp_line_number),
      .rsp_column_number(rsp_column_number),
      .rsp_run_last(rsp_run_last),
      .rsp_input_done(rsp_input_done)
   );

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_text_byte = '0;
      req_end_of_input = 1'b0;
      rsp_stall = 1'b0;
      sender_gap_pct = 0;
      receiver_stall_pct = 0;
      hold_request = 0;
      hold_left = 0;
      idle_cycles = 0;
      bytes_sent = 0;
      tracker = new();
   end

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      lexeme_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.lexeme_byte = rsp_lexeme_byte;
         got.lexeme_start = rsp_lexeme_start;
         got.lexeme_kind = kind_type'(rsp_lexeme_kind);
         got.line_number = rsp_line_number;
         got.column_number = rsp_column_number;
         got.run_last = rsp_run_last;
         got.input_done = rsp_input_done;
         tracker.check_lexeme(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_byte(input logic [7:0] b, input logic eoi);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_text_byte = b;
      req_end_of_input = eoi;
      do @(posedge clock); while (req_stall);
      tracker.note_byte(b, eoi);
      bytes_sent++;
      @(negedge clock);
   endtask

   function automatic logic [7:0] word_char();
      int pick;
      pick = $urandom_range(9);
      if (pick < 6) return 8'($urandom_range(8'h61, 8'h7a));
      if (pick < 8) return 8'($urandom_range(8'h30, 8'h39));
      if (pick < 9) return 8'($urandom_range(8'h80, 8'hff));
      return 8'h09;
   endfunction

   task automatic send_random_token(input logic last_eoi);
      int pick;
      int len;
      logic [7:0] b;
      pick = $urandom_range(99);
      if (pick < 30) begin
         len = $urandom_range(1, 6);
         for (int i = 0; i < len; i++) send_byte(word_char(), last_eoi && i == len - 1);
      end else if (pick < 42) begin
         send_byte(($urandom_range(1) == 0) ? CHAR_SPACE : 8'h0D, last_eoi);
      end else if (pick < 50) begin
         send_byte(CHAR_NEWLINE, last_eoi);
      end else if (pick < 58) begin
         case ($urandom_range(5))
            0: b = CHAR_SEMICOLON;
            1: b = CHAR_LPAREN;
            2: b = CHAR_RPAREN;
            3: b = CHAR_LBRACE;
            4: b = CHAR_RBRACE;
            default: b = CHAR_COMMA;
         endcase
         send_byte(b, last_eoi);
      end else if (pick < 66) begin
         case ($urandom_range(2))
            0: b = CHAR_PLUS;
            1: b = CHAR_MINUS;
            default: b = CHAR_STAR;
         endcase
         send_byte(b, last_eoi);
      end else if (pick < 70) begin
         send_byte(CHAR_SLASH, last_eoi);
      end else if (pick < 78) begin
         len = $urandom_range(0, 5);
         send_byte(CHAR_QUOTE, 1'b0);
         for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            if (b == CHAR_QUOTE) b = word_char();
            send_byte(b, 1'b0);
         end
         if ($urandom_range(7) != 0) send_byte(CHAR_QUOTE, last_eoi);
      end else if (pick < 83) begin
         len = $urandom_range(0, 4);
         send_byte(CHAR_SLASH, 1'b0);
         send_byte(CHAR_SLASH, 1'b0);
         for (int i = 0; i < len; i++) send_byte(word_char(), 1'b0);
         send_byte(CHAR_NEWLINE, last_eoi);
      end else if (pick < 89) begin
         len = $urandom_range(0, 5);
         send_byte(CHAR_SLASH, 1'b0);
         send_byte(CHAR_STAR, 1'b0);
         for (int i = 0; i < len; i++) begin
            b = ($urandom_range(3) == 0) ? CHAR_STAR : 8'($urandom_range(255));
            send_byte(b, 1'b0);
         end
         len = $urandom_range(1, 3);
         for (int i = 0; i < len; i++) send_byte(CHAR_STAR, 1'b0);
         send_byte(CHAR_SLASH, last_eoi);
      end else begin
         send_byte(8'($urandom_range(255)), last_eoi);
      end
   endtask

   task automatic send_random_text(input int count);
      int stop_at;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) send_random_token($urandom_range(29) == 0);
   endtask

   initial begin
      logic [7:0] directed_text[$];
      #0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      sender_gap_pct = 32;
      receiver_stall_pct = 66;
      directed_text = {8'h61, 8'hff, CHAR_SLASH, 8'h62, 8'h09, CHAR_SEMICOLON, CHAR_LPAREN,
                       CHAR_RPAREN, CHAR_LBRACE, CHAR_RBRACE, CHAR_COMMA, CHAR_PLUS,
                       CHAR_MINUS, CHAR_STAR, CHAR_QUOTE, CHAR_QUOTE, CHAR_QUOTE, 8'h00,
                       CHAR_NEWLINE, CHAR_QUOTE, CHAR_SPACE, CHAR_SLASH, CHAR_SLASH, 8'h7a,
                       CHAR_NEWLINE, CHAR_SLASH, CHAR_STAR, CHAR_STAR, CHAR_STAR,
                       CHAR_SLASH};
      foreach (directed_text[i]) send_byte(directed_text[i], 1'b0);
      send_byte(CHAR_SLASH, 1'b1);
      send_byte(CHAR_QUOTE, 1'b0);
      send_byte(8'h71, 1'b1);
      send_random_text(330);

      sender_gap_pct = 66;
      receiver_stall_pct = 32;
      send_random_text(340);

      sender_gap_pct = 0;
      receiver_stall_pct = 0;
      req_valid = 1'b0;
      @(posedge clock);
      hold_request = HOLD_CYCLES;
      @(negedge clock);
      send_random_text(340);

      send_byte(8'h6b, 1'b0);
      send_byte(CHAR_SLASH, 1'b1);
      req_valid = 1'b0;
      req_end_of_input = 1'b0;

      while (tracker.expected_lexemes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.expected_lexemes.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sbt_pkg.sv
rtl/source_byte_tokenizer.sv
tb/sv/source_byte_tokenizer_tb.sv
